// ===== hdl/rdq_pkg.sv =====
// Shared types and constants of the ring deque: field widths, operation kind
// codes, status codes and the command record passed from front to back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rdq_pkg;

	// Field widths of the item and result channels
	localparam int KIND_W = 3;
	localparam int DATA_W = 32;
	localparam int PTR_W  = 4;
	localparam int STAT_W = 2;

	// Default store geometry
	localparam int SLOTS_DEF        = 16;
	localparam int ELEMENT_BITS_DEF = 32;

	// Operation kind codes on the input channel
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RAW_READ   = 3'd4;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// Decoded operation
	typedef enum logic [2:0] {
		OP_NOP,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_RAW_READ
	} op_t;

	// Command record between front and back
	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] value;
		logic [PTR_W-1:0]  slot;
	} cmd_t;

endpackage

`default_nettype wire

// ===== hdl/rdq_front.sv =====
// Front end of the ring deque: accepts items, decodes the kind into an
// operation and holds the command in one register stage.
// Depends on rdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdq_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire [rdq_pkg::KIND_W-1:0]    kind,
	input  wire [rdq_pkg::DATA_W-1:0]    push_value,
	input  wire [rdq_pkg::PTR_W-1:0]     slot,
	output logic                         cmd_valid,
	input  wire                          cmd_stall,
	output rdq_pkg::cmd_t                cmd
);
	import rdq_pkg::*;

	logic cmd_valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_dec;

	// Decode the kind field
	always_comb begin
		cmd_dec.value = push_value;
		cmd_dec.slot  = slot;
		unique case (kind)
			KIND_PUSH_FRONT: cmd_dec.op = OP_PUSH_FRONT;
			KIND_PUSH_BACK:  cmd_dec.op = OP_PUSH_BACK;
			KIND_POP_FRONT:  cmd_dec.op = OP_POP_FRONT;
			KIND_POP_BACK:   cmd_dec.op = OP_POP_BACK;
			KIND_RAW_READ:   cmd_dec.op = OP_RAW_READ;
			default:         cmd_dec.op = OP_NOP;
		endcase
	end

	// Hold the stage while the queue refuses it
	assign in_stall = cmd_valid_s1 && cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			cmd_valid_s1 <= in_valid;
		end
	end

	// Capture the decoded command of an accepted item
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1 <= cmd_dec;
		end
	end

	assign cmd_valid = cmd_valid_s1;
	assign cmd       = cmd_s1;

endmodule

`default_nettype wire

// ===== hdl/rdq_queue.sv =====
// Two-entry command queue that decouples the front end from the back end.
// Depends on rdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdq_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push_valid,
	output logic           push_stall,
	input  rdq_pkg::cmd_t  push_cmd,
	output logic           pop_valid,
	input  wire            pop_stall,
	output rdq_pkg::cmd_t  pop_cmd
);
	import rdq_pkg::*;

	localparam int ENTRIES = 2;

	cmd_t       ent_q [ENTRIES];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_stall = (count_q == 2'(ENTRIES));
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = ent_q[rd_ptr_q];
	assign do_push    = push_valid && !push_stall;
	assign do_pop     = pop_valid && !pop_stall;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Store an incoming command
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rdq_back.sv =====
// Back end of the ring deque: owns the pointers, capacity register and slot
// store, executes one command per cycle unless the output register stalls.
// Depends on rdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdq_back #(
	parameter int SLOTS        = rdq_pkg::SLOTS_DEF,
	parameter int ELEMENT_BITS = rdq_pkg::ELEMENT_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_wr_en,
	input  wire [rdq_pkg::PTR_W-1:0]     cfg_wr_data,
	input  wire                          cmd_valid,
	output logic                         cmd_stall,
	input  rdq_pkg::cmd_t                cmd,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [rdq_pkg::DATA_W-1:0]   read_value,
	output logic [rdq_pkg::STAT_W-1:0]   status,
	output logic                         is_empty,
	output logic                         is_full,
	output logic [rdq_pkg::PTR_W-1:0]    front_position,
	output logic [rdq_pkg::PTR_W-1:0]    back_position
);
	import rdq_pkg::*;

	// Only slots below the ring's largest length are ever reached
	localparam int RING_MAX = 1 << PTR_W;
	localparam int DEPTH    = (SLOTS < RING_MAX) ? SLOTS : RING_MAX;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int MAX_CAP  = DEPTH - 1;

	logic [ELEMENT_BITS-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]        vld_q;
	logic [PTR_W-1:0]        cap_q;
	logic [PTR_W-1:0]        front_q;
	logic [PTR_W-1:0]        back_q;
	logic                    out_valid_q;
	logic [DATA_W-1:0]       read_value_q;
	logic [STAT_W-1:0]       status_q;
	logic                    is_empty_q;
	logic                    is_full_q;
	logic [PTR_W-1:0]        front_pos_q;
	logic [PTR_W-1:0]        back_pos_q;

	logic                    take;
	logic                    empty_now;
	logic                    full_now;
	logic [PTR_W-1:0]        front_n;
	logic [PTR_W-1:0]        back_n;
	logic [STAT_W-1:0]       status_n;
	logic                    wr_en;
	logic [PTR_W-1:0]        wr_ptr;
	logic                    rd_en;
	logic [PTR_W-1:0]        rd_ptr;
	logic                    slot_in_range;
	logic [PTR_W-1:0]        cap_wr;

	function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p,
			input logic [PTR_W-1:0] last);
		return (p == last) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] p,
			input logic [PTR_W-1:0] last);
		return (p == '0) ? last : p - 1'b1;
	endfunction

	// Take a command when the output register is free or being drained
	assign cmd_stall = out_valid_q && out_stall;
	assign take      = cmd_valid && !cmd_stall;

	assign empty_now     = (ring_inc(front_q, cap_q) == back_q);
	assign full_now      = (ring_inc(ring_inc(front_q, cap_q), cap_q) == back_q);
	assign slot_in_range = ({1'b0, cmd.slot} < (PTR_W + 1)'(DEPTH));

	// Clamp a written capacity to between one and what the store can hold
	always_comb begin
		if (cfg_wr_data == '0) begin
			cap_wr = PTR_W'(1);
		end else if (cfg_wr_data > PTR_W'(MAX_CAP)) begin
			cap_wr = PTR_W'(MAX_CAP);
		end else begin
			cap_wr = cfg_wr_data;
		end
	end

	// Execute the command against the current pointers
	always_comb begin
		front_n  = front_q;
		back_n   = back_q;
		status_n = ST_OK;
		wr_en    = 1'b0;
		wr_ptr   = front_q;
		rd_en    = 1'b0;
		rd_ptr   = front_q;
		unique case (cmd.op)
			OP_PUSH_FRONT: begin
				if (full_now) begin
					status_n = ST_FULL;
				end else begin
					front_n = ring_inc(front_q, cap_q);
					wr_en   = 1'b1;
					wr_ptr  = front_n;
				end
			end
			OP_PUSH_BACK: begin
				if (full_now) begin
					status_n = ST_FULL;
				end else begin
					back_n = ring_dec(back_q, cap_q);
					wr_en  = 1'b1;
					wr_ptr = back_n;
				end
			end
			OP_POP_FRONT: begin
				if (empty_now) begin
					status_n = ST_EMPTY;
				end else begin
					rd_en   = 1'b1;
					rd_ptr  = front_q;
					front_n = ring_dec(front_q, cap_q);
				end
			end
			OP_POP_BACK: begin
				if (empty_now) begin
					status_n = ST_EMPTY;
				end else begin
					rd_en  = 1'b1;
					rd_ptr = back_q;
					back_n = ring_inc(back_q, cap_q);
				end
			end
			OP_RAW_READ: begin
				rd_en  = slot_in_range;
				rd_ptr = cmd.slot;
			end
			default: begin
			end
		endcase
	end

	// Capacity and pointers; a capacity write empties the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= PTR_W'(MAX_CAP);
			front_q <= PTR_W'(MAX_CAP);
			back_q  <= '0;
		end else if (cfg_wr_en) begin
			cap_q   <= cap_wr;
			front_q <= cap_wr;
			back_q  <= '0;
		end else if (take) begin
			front_q <= front_n;
			back_q  <= back_n;
		end
	end

	// Valid bits: a slot never written since reset or a capacity write reads zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cfg_wr_en) begin
			vld_q <= '0;
		end else if (take && wr_en) begin
			vld_q[wr_ptr[IDX_W-1:0]] <= 1'b1;
		end
	end

	// Slot store write
	always_ff @(posedge clk) begin
		if (take && wr_en) begin
			mem_q[wr_ptr[IDX_W-1:0]] <= ELEMENT_BITS'(cmd.value);
		end
	end

	// Result register, loaded with the store read
	always_ff @(posedge clk) begin
		if (take) begin
			if (rd_en && vld_q[rd_ptr[IDX_W-1:0]]) begin
				read_value_q <= DATA_W'(mem_q[rd_ptr[IDX_W-1:0]]);
			end else begin
				read_value_q <= '0;
			end
			status_q    <= status_n;
			is_empty_q  <= (ring_inc(front_n, cap_q) == back_n);
			is_full_q   <= (ring_inc(ring_inc(front_n, cap_q), cap_q) == back_n);
			front_pos_q <= front_n;
			back_pos_q  <= back_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!cmd_stall) begin
			out_valid_q <= cmd_valid;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_value     = read_value_q;
	assign status         = status_q;
	assign is_empty       = is_empty_q;
	assign is_full        = is_full_q;
	assign front_position = front_pos_q;
	assign back_position  = back_pos_q;

endmodule

`default_nettype wire

// ===== hdl/ring_deque_top.sv =====
// Ring deque top level: front end, command queue and back end.
// Depends on rdq_pkg, rdq_front, rdq_queue and rdq_back.
//
// Usage:
//   Items enter on in_valid/in_stall with kind, push_value and slot; results
//   leave on out_valid/out_stall, one result per item, in item order.
//   The capacity register is written with cfg_wr_en/cfg_wr_data while the
//   block is idle; a write empties the deque (pointers reset, store reads 0).
//   An accepted item passes the front register, a queue entry and the output
//   register, in that order, before its result shows.
//   Throughput: one item per cycle while out_stall is low, set by the back end,
//   which does one pointer update and one slot store access per cycle.
//   Reset: capacity 15 (clamped to the store size), deque empty, every slot
//   reads zero, no result pending.
//   When out_stall is high the output register holds its result, the queue
//   fills its two entries, the front register fills, and then in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module ring_deque_top #(
	parameter int SLOTS        = rdq_pkg::SLOTS_DEF,
	parameter int ELEMENT_BITS = rdq_pkg::ELEMENT_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_wr_en,
	input  wire [rdq_pkg::PTR_W-1:0]     cfg_wr_data,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire [rdq_pkg::KIND_W-1:0]    kind,
	input  wire [rdq_pkg::DATA_W-1:0]    push_value,
	input  wire [rdq_pkg::PTR_W-1:0]     slot,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [rdq_pkg::DATA_W-1:0]   read_value,
	output logic [rdq_pkg::STAT_W-1:0]   status,
	output logic                         is_empty,
	output logic                         is_full,
	output logic [rdq_pkg::PTR_W-1:0]    front_position,
	output logic [rdq_pkg::PTR_W-1:0]    back_position
);
	import rdq_pkg::*;

	logic fr_valid;
	logic fr_stall;
	cmd_t fr_cmd;
	logic bk_valid;
	logic bk_stall;
	cmd_t bk_cmd;

	rdq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.push_value (push_value),
		.slot       (slot),
		.cmd_valid  (fr_valid),
		.cmd_stall  (fr_stall),
		.cmd        (fr_cmd)
	);

	rdq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_stall (fr_stall),
		.push_cmd   (fr_cmd),
		.pop_valid  (bk_valid),
		.pop_stall  (bk_stall),
		.pop_cmd    (bk_cmd)
	);

	rdq_back #(
		.SLOTS        (SLOTS),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.cmd_valid      (bk_valid),
		.cmd_stall      (bk_stall),
		.cmd            (bk_cmd),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_value     (read_value),
		.status         (status),
		.is_empty       (is_empty),
		.is_full        (is_full),
		.front_position (front_position),
		.back_position  (back_position)
	);

endmodule

`default_nettype wire

// ===== hdl/rdq_checker.sv =====
// Port-level checks of the ring deque, bound to ring_deque_top.
// Depends on rdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdq_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          out_valid,
	input  wire                          out_stall,
	input  wire [rdq_pkg::DATA_W-1:0]    read_value,
	input  wire [rdq_pkg::STAT_W-1:0]    status,
	input  wire                          is_empty,
	input  wire                          is_full
);
	import rdq_pkg::*;

	// A refused push leaves the ring full
	a_full_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> is_full)
		else $error("push refused while ring not full");

	// A refused pop leaves the ring empty
	a_empty_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> is_empty)
		else $error("pop refused while ring not empty");

	// A refused operation returns zero
	a_refusal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (read_value == '0))
		else $error("refused operation returned data");

	// Capacity is at least one, so empty and full never coincide
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_empty && is_full))
		else $error("empty and full flags both set");

	// A stalled result holds
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(read_value) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind ring_deque_top rdq_checker u_rdq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.read_value (read_value),
	.status     (status),
	.is_empty   (is_empty),
	.is_full    (is_full)
);

`default_nettype wire

// ===== tb/rdq_result_checker.sv =====
// Ring deque result checker: watches both channels and the capacity port,
// predicts every result and compares it field by field. Depends on rdq_pkg.
`timescale 1ns / 1ps

module rdq_result_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_wr_en,
	input  wire [rdq_pkg::PTR_W-1:0]     cfg_wr_data,
	input  wire                          in_valid,
	input  wire                          in_stall,
	input  wire [rdq_pkg::KIND_W-1:0]    kind,
	input  wire [rdq_pkg::DATA_W-1:0]    push_value,
	input  wire [rdq_pkg::PTR_W-1:0]     slot,
	input  wire                          out_valid,
	input  wire                          out_stall,
	input  wire [rdq_pkg::DATA_W-1:0]    read_value,
	input  wire [rdq_pkg::STAT_W-1:0]    status,
	input  wire                          is_empty,
	input  wire                          is_full,
	input  wire [rdq_pkg::PTR_W-1:0]     front_position,
	input  wire [rdq_pkg::PTR_W-1:0]     back_position,
	output int                           mismatches,
	output int                           outstanding,
	output int                           checked,
	output int                           full_refusals,
	output int                           empty_refusals
);
	import rdq_pkg::*;

	localparam logic [PTR_W-1:0] CAPACITY_AT_RESET = 4'd15;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [STAT_W-1:0] stat;
		logic              empty;
		logic              full;
		logic [PTR_W-1:0]  front;
		logic [PTR_W-1:0]  back;
	} deque_result_t;

	// Mirror of the deque state
	logic [DATA_W-1:0] slot_mem [SLOTS_DEF];
	logic [PTR_W-1:0]  capacity_reg;
	int                front_ptr;
	int                back_ptr;
	deque_result_t     expected_results [$];

	int n_mismatch = 0;
	int n_checked  = 0;
	int n_full     = 0;
	int n_empty    = 0;

	// Ring length: clamped capacity plus the one slot that stays empty
	function automatic int ring_length();
		int cap;
		cap = int'(capacity_reg);
		if (cap < 1) cap = 1;
		if (cap > SLOTS_DEF - 1) cap = SLOTS_DEF - 1;
		return cap + 1;
	endfunction

	function automatic bit deque_empty(input int len);
		return ((front_ptr + 1) % len) == back_ptr;
	endfunction

	function automatic bit deque_full(input int len);
		return ((front_ptr + 2) % len) == back_ptr;
	endfunction

	// Empty the deque and zero the store
	task automatic clear_deque();
		foreach (slot_mem[i]) slot_mem[i] = '0;
		front_ptr = ring_length() - 1;
		back_ptr  = 0;
	endtask

	// Apply one operation to the mirror and build its result
	task automatic apply_op(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] v,
			input logic [PTR_W-1:0] s, output deque_result_t r);
		int len;
		len = ring_length();
		r = '0;
		r.stat = ST_OK;
		case (k)
			KIND_PUSH_FRONT: begin
				if (deque_full(len)) begin
					r.stat = ST_FULL;
				end else begin
					front_ptr = (front_ptr + 1) % len;
					slot_mem[front_ptr] = v;
				end
			end
			KIND_PUSH_BACK: begin
				if (deque_full(len)) begin
					r.stat = ST_FULL;
				end else begin
					back_ptr = (back_ptr + len - 1) % len;
					slot_mem[back_ptr] = v;
				end
			end
			KIND_POP_FRONT: begin
				if (deque_empty(len)) begin
					r.stat = ST_EMPTY;
				end else begin
					r.value = slot_mem[front_ptr];
					front_ptr = (front_ptr + len - 1) % len;
				end
			end
			KIND_POP_BACK: begin
				if (deque_empty(len)) begin
					r.stat = ST_EMPTY;
				end else begin
					r.value = slot_mem[back_ptr];
					back_ptr = (back_ptr + 1) % len;
				end
			end
			KIND_RAW_READ: begin
				r.value = slot_mem[s];
			end
			default: begin
			end
		endcase
		r.empty = deque_empty(len);
		r.full  = deque_full(len);
		r.front = front_ptr[PTR_W-1:0];
		r.back  = back_ptr[PTR_W-1:0];
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			n_mismatch++;
		end
	endtask

	// Compare results, track capacity writes, predict accepted items
	always @(posedge clk or negedge arst_n) begin
		deque_result_t want;
		if (!arst_n) begin
			capacity_reg = CAPACITY_AT_RESET;
			clear_deque();
			expected_results.delete();
		end else begin
			if (out_valid && !out_stall) begin
				n_checked++;
				if (expected_results.size() == 0) begin
					$error("result arrived with no item outstanding");
					n_mismatch++;
				end else begin
					want = expected_results.pop_front();
					check_field("read_value", want.value, read_value);
					check_field("status", DATA_W'(want.stat), DATA_W'(status));
					check_field("is_empty", DATA_W'(want.empty), DATA_W'(is_empty));
					check_field("is_full", DATA_W'(want.full), DATA_W'(is_full));
					check_field("front_position", DATA_W'(want.front),
						DATA_W'(front_position));
					check_field("back_position", DATA_W'(want.back),
						DATA_W'(back_position));
				end
			end
			if (cfg_wr_en) begin
				capacity_reg = cfg_wr_data;
				clear_deque();
			end
			if (in_valid && !in_stall) begin
				apply_op(kind, push_value, slot, want);
				if (want.stat == ST_FULL) n_full++;
				if (want.stat == ST_EMPTY) n_empty++;
				expected_results.push_back(want);
			end
		end
		mismatches     <= n_mismatch;
		outstanding    <= expected_results.size();
		checked        <= n_checked;
		full_refusals  <= n_full;
		empty_refusals <= n_empty;
	end

endmodule

// ===== tb/tb_ring_deque_top.sv =====
// Ring deque testbench top: clock, reset, stimulus and verdict.
// Depends on rdq_pkg, ring_deque_top and rdq_result_checker.
`timescale 1ns / 1ps

module tb_ring_deque_top;
	import rdq_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int DRAIN_MARGIN    = 8;
	localparam logic [KIND_W-1:0] KIND_SPARE_LO  = KIND_RAW_READ + 3'd1;
	localparam logic [KIND_W-1:0] KIND_SPARE_TOP = '1;
	localparam logic [PTR_W-1:0] CAP_SCHEDULE [5] = '{4'd15, 4'd2, 4'd1, 4'd0, 4'd7};

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [PTR_W-1:0]   cfg_wr_data = '0;
	logic               in_valid    = 1'b0;
	logic [KIND_W-1:0]  kind        = '0;
	logic [DATA_W-1:0]  push_value  = '0;
	logic [PTR_W-1:0]   slot        = '0;
	logic               out_stall   = 1'b0;
	logic               in_stall;
	logic               out_valid;
	logic [DATA_W-1:0]  read_value;
	logic [STAT_W-1:0]  status;
	logic               is_empty;
	logic               is_full;
	logic [PTR_W-1:0]   front_position;
	logic [PTR_W-1:0]   back_position;

	int mismatches;
	int outstanding;
	int checked;
	int full_refusals;
	int empty_refusals;

	int cycle_count   = 0;
	int items_sent    = 0;
	int capacity_sets = 0;
	int idle_pct      = 0;
	int stall_pct     = 0;
	int stall_left    = 0;

	ring_deque_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.push_value     (push_value),
		.slot           (slot),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_value     (read_value),
		.status         (status),
		.is_empty       (is_empty),
		.is_full        (is_full),
		.front_position (front_position),
		.back_position  (back_position)
	);

	rdq_result_checker u_result_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.push_value     (push_value),
		.slot           (slot),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_value     (read_value),
		.status         (status),
		.is_empty       (is_empty),
		.is_full        (is_full),
		.front_position (front_position),
		.back_position  (back_position),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.checked        (checked),
		.full_refusals  (full_refusals),
		.empty_refusals (empty_refusals)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stall the result channel in random bursts
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
			stall_left = $urandom_range(1, 19);
		out_stall <= (stall_left > 0);
	end

	// Offer one item, maybe after an idle burst, and hold it until accepted
	task automatic send_item(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] v,
			input logic [PTR_W-1:0] s);
		int gap;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		push_value <= v;
		slot       <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_MARGIN) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [PTR_W-1:0] cap);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		capacity_sets++;
	endtask

	// Favor pushes while filling and pops while emptying
	function automatic logic [KIND_W-1:0] pick_kind(input bit filling);
		int roll;
		bit push;
		roll = $urandom_range(0, 99);
		if (roll < 4) return KIND_W'(KIND_RAW_READ + $urandom_range(1, 3));
		if (roll < 12) return KIND_RAW_READ;
		push = ((roll < 70) == filling);
		if (push) return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
		return $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int run_left;
		bit filling;
		logic [PTR_W-1:0] cap;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset capacity: zeroed store, refused pops, both ends, spare kinds
		send_item(KIND_RAW_READ, '1, 4'd0);
		send_item(KIND_RAW_READ, '0, 4'd15);
		send_item(KIND_POP_FRONT, '1, '0);
		send_item(KIND_POP_BACK, '1, '0);
		send_item(KIND_PUSH_FRONT, '1, '0);
		send_item(KIND_PUSH_BACK, '0, '1);
		send_item(KIND_PUSH_BACK, 32'hA5A5_5A5A, '0);
		send_item(KIND_POP_FRONT, '0, '0);
		send_item(KIND_POP_BACK, '0, '0);
		send_item(KIND_POP_BACK, '0, '0);
		send_item(KIND_SPARE_LO, '1, '1);
		send_item(KIND_SPARE_TOP, '1, '0);
		send_item(KIND_RAW_READ, '0, 4'd15);

		// Smallest ring: one element fills it
		drain();
		write_capacity(4'd1);
		send_item(KIND_PUSH_FRONT, 32'h1234_5678, '0);
		send_item(KIND_PUSH_BACK, '1, '0);
		send_item(KIND_PUSH_FRONT, '1, '0);
		send_item(KIND_RAW_READ, '0, 4'd1);
		send_item(KIND_POP_BACK, '0, '0);
		send_item(KIND_POP_FRONT, '0, '0);

		// Capacity zero behaves as one
		drain();
		write_capacity(4'd0);
		send_item(KIND_PUSH_BACK, '1, '0);
		send_item(KIND_PUSH_FRONT, 32'h0F0F_F0F0, '0);
		send_item(KIND_POP_FRONT, '0, '0);
		send_item(KIND_SPARE_LO + 3'd1, '0, '0);
		send_item(KIND_RAW_READ, '0, 4'd15);

		// Random phases, each under its own capacity and idling mix
		filling = 1'b0;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			if (ph == RANDOM_PHASES - 1) begin
				idle_pct  = 0;
				stall_pct = 0;
			end else if (ph == 0) begin
				idle_pct  = 20;
				stall_pct = 20;
			end else begin
				idle_pct  = 15 * $urandom_range(0, 2);
				stall_pct = 15 * $urandom_range(0, 2);
			end
			cap = (ph < 5) ? CAP_SCHEDULE[ph] : PTR_W'($urandom_range(0, 15));
			write_capacity(cap);
			run_left = 0;
			repeat (ITEMS_PER_PHASE) begin
				if (run_left == 0) begin
					filling  = !filling;
					run_left = $urandom_range(4, 40);
				end
				run_left--;
				send_item(pick_kind(filling), pick_value(), PTR_W'($urandom_range(0, 15)));
			end
		end

		drain();
		$display("Sent %0d items under %0d capacity writes; %0d results compared.",
			items_sent, capacity_sets, checked);
		$display("Pushes refused on full: %0d, pops refused on empty: %0d.",
			full_refusals, empty_refusals);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
